// File: rtl/sign_magnitude_q32_16_alu_assert.svh
// Assertion macros for the sign-magnitude Q32.16 unit
`ifndef SIGN_MAGNITUDE_Q32_16_ALU_ASSERT_SVH
`define SIGN_MAGNITUDE_Q32_16_ALU_ASSERT_SVH

`ifndef SYNTH
`define SMQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("smq32_alu assertion failed");
`define SMQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("smq32_alu assertion failed");
`else
`define SMQ_ASSERT(lbl, clk, rst_n, prop)
`define SMQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/smq32_alu_pkg.sv
// Widths, request codes and constants of the sign-magnitude Q32.16 unit
`timescale 1ns / 1ps

package smq32_alu_pkg;

    localparam int INT_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int MAG_W   = INT_W + FRAC_W;
    localparam int REQ_W   = 3;

    typedef logic [REQ_W-1:0]  t_req_code;
    typedef logic [INT_W-1:0]  t_int;
    typedef logic [FRAC_W-1:0] t_frac;
    typedef logic [MAG_W-1:0]  t_mag;

    localparam t_req_code REQ_FROM_INT   = 3'd0;
    localparam t_req_code REQ_FROM_FLOAT = 3'd1;
    localparam t_req_code REQ_ADD        = 3'd2;
    localparam t_req_code REQ_MULT       = 3'd3;
    localparam t_req_code REQ_TO_INT     = 3'd4;

    localparam t_int  INT_SAT  = 32'hffff_ffff;
    localparam t_frac FRAC_SAT = 16'hffff;

    // single precision exponent points
    localparam logic [7:0] EXP_SPECIAL = 8'd255;
    localparam logic [7:0] EXP_TOO_BIG = 8'd159;
    localparam logic [7:0] EXP_SHIFT0  = 8'd158;
    localparam logic [7:0] EXP_VANISH  = 8'd110;

endpackage

// File: rtl/smq32_alu_if.sv
// Request and result channel interfaces
`timescale 1ns / 1ps

interface smq32_alu_req_if;
    logic                              valid;
    logic                              ready;
    smq32_alu_pkg::t_req_code          req_type;
    logic                              a_sign;
    smq32_alu_pkg::t_int               a_int;
    smq32_alu_pkg::t_frac              a_frac;
    logic                              b_sign;
    smq32_alu_pkg::t_int               b_int;
    smq32_alu_pkg::t_frac              b_frac;
    logic signed [smq32_alu_pkg::INT_W-1:0] int_in;
    logic [31:0]                       float_bits;

    modport source (output valid, req_type, a_sign, a_int, a_frac, b_sign, b_int,
                    b_frac, int_in, float_bits, input ready);
    modport sink   (input valid, req_type, a_sign, a_int, a_frac, b_sign, b_int,
                    b_frac, int_in, float_bits, output ready);
endinterface

interface smq32_alu_res_if;
    logic                              valid;
    logic                              ready;
    logic                              r_sign;
    smq32_alu_pkg::t_int               r_int;
    smq32_alu_pkg::t_frac              r_frac;
    logic signed [smq32_alu_pkg::INT_W-1:0] int_out;

    modport source (output valid, r_sign, r_int, r_frac, int_out, input ready);
    modport sink   (input valid, r_sign, r_int, r_frac, int_out, output ready);
endinterface

// File: rtl/sign_magnitude_q32_16_alu.sv
// Throughput with o_res ready: one item per cycle; stage 1 holds the four
// partial products of the multiply, stage 2 the wide adds and the float
// shift, stage 3 the output.
// A stall on o_res holds only the stages behind a full one; bubbles collapse.
// Reset (synchronous, active low) clears the stage valid bits only.
`timescale 1ns / 1ps
`include "sign_magnitude_q32_16_alu_assert.svh"

module sign_magnitude_q32_16_alu (
    input  logic            i_clk,
    input  logic            i_rst_n,
    smq32_alu_req_if.sink   i_req,
    smq32_alu_res_if.source o_res
);

    // handshake
    logic w_rdy1, w_rdy2, w_rdy3;
    logic r_v1, r_v2, r_v3;

    // stage 1
    smq32_alu_pkg::t_req_code r_req1;
    logic                     r_sgn1;
    smq32_alu_pkg::t_int      r_int1;
    logic                     r_fsat1, r_fzero1;
    logic [5:0]               r_fsh1;
    logic [22:0]              r_fman1;
    smq32_alu_pkg::t_mag      r_ta1, r_tb1;
    logic [31:0]              r_p_ii1, r_p_ff1;
    logic [47:0]              r_p_if1, r_p_fi1;

    smq32_alu_pkg::t_req_code n_req1;
    logic                     n_sgn1;
    smq32_alu_pkg::t_int      n_int1;
    logic                     n_fsat1, n_fzero1;
    logic [7:0]               w_exp, w_shamt;
    logic [22:0]              w_man;
    smq32_alu_pkg::t_mag      w_amag, w_bmag;

    // stage 2
    smq32_alu_pkg::t_req_code r_req2;
    logic                     r_sgn2;
    smq32_alu_pkg::t_int      r_int2;
    logic                     r_fsat2;
    smq32_alu_pkg::t_mag      r_fv2;
    smq32_alu_pkg::t_mag      r_sum2;
    logic [48:0]              r_mid2;
    logic [31:0]              r_p_ii2, r_p_ff2;

    // stage 3 / output
    smq32_alu_pkg::t_req_code r_req3;
    logic                     r_sgn3;
    smq32_alu_pkg::t_int      r_int3;
    smq32_alu_pkg::t_frac     r_frac3;
    smq32_alu_pkg::t_int      r_iout3;

    logic                     n_sgn3;
    smq32_alu_pkg::t_int      n_int3;
    smq32_alu_pkg::t_frac     n_frac3;
    smq32_alu_pkg::t_int      n_iout3;
    smq32_alu_pkg::t_mag      w_addmag, w_mulp;

    assign w_rdy3      = !r_v3 || o_res.ready;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign i_req.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_req.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // ---------------- stage 1: decode, negate, partial products
    assign w_exp   = i_req.float_bits[30:23];
    assign w_man   = i_req.float_bits[22:0];
    assign w_shamt = 8'(smq32_alu_pkg::EXP_SHIFT0 - w_exp);
    assign w_amag  = {i_req.a_int, i_req.a_frac};
    assign w_bmag  = {i_req.b_int, i_req.b_frac};

    always_comb begin
        n_req1   = i_req.req_type;
        n_sgn1   = 1'b0;
        n_int1   = '0;
        n_fsat1  = 1'b0;
        n_fzero1 = 1'b0;
        unique case (i_req.req_type)
            smq32_alu_pkg::REQ_FROM_INT: begin
                n_sgn1 = i_req.int_in[31];
                n_int1 = n_sgn1 ? 32'(-i_req.int_in) : 32'(i_req.int_in);
            end
            smq32_alu_pkg::REQ_FROM_FLOAT: begin
                n_sgn1 = i_req.float_bits[31] && (i_req.float_bits[30:0] != '0);
                if (w_exp == smq32_alu_pkg::EXP_SPECIAL) begin
                    n_fsat1 = 1'b1;
                    if (w_man != '0) n_sgn1 = 1'b0;  // NaN
                end else if (w_exp >= smq32_alu_pkg::EXP_TOO_BIG) begin
                    n_fsat1 = 1'b1;
                end
                // subnormal, or shifted entirely below 2^-16
                n_fzero1 = (w_exp == '0) || (w_exp <= smq32_alu_pkg::EXP_VANISH);
            end
            smq32_alu_pkg::REQ_MULT: begin
                n_sgn1 = i_req.a_sign ^ i_req.b_sign;
            end
            smq32_alu_pkg::REQ_TO_INT: begin
                n_int1 = i_req.a_sign ? 32'(-i_req.a_int) : i_req.a_int;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && w_rdy1) begin
            r_req1   <= n_req1;
            r_sgn1   <= n_sgn1;
            r_int1   <= n_int1;
            r_fsat1  <= n_fsat1;
            r_fzero1 <= n_fzero1;
            r_fsh1   <= w_shamt[5:0];
            r_fman1  <= w_man;
            r_ta1    <= i_req.a_sign ? 48'(-w_amag) : w_amag;
            r_tb1    <= i_req.b_sign ? 48'(-w_bmag) : w_bmag;
            // only the low half of int*int survives the 64-bit wrap
            r_p_ii1  <= 32'(i_req.a_int * i_req.b_int);
            r_p_if1  <= 48'(i_req.a_int) * 48'(i_req.b_frac);
            r_p_fi1  <= 48'(i_req.a_frac) * 48'(i_req.b_int);
            r_p_ff1  <= 32'(i_req.a_frac) * 32'(i_req.b_frac);
        end
    end

    // ---------------- stage 2: add, middle partial sum, float shift
    always_ff @(posedge i_clk) begin
        if (r_v1 && w_rdy2) begin
            r_req2  <= r_req1;
            r_sgn2  <= r_sgn1;
            r_int2  <= r_int1;
            r_fsat2 <= r_fsat1;
            r_fv2   <= r_fzero1 ? '0 : ({1'b1, r_fman1, 24'b0} >> r_fsh1);
            r_sum2  <= r_ta1 + r_tb1;
            r_mid2  <= 49'(r_p_if1) + 49'(r_p_fi1);
            r_p_ii2 <= r_p_ii1;
            r_p_ff2 <= r_p_ff1;
        end
    end

    // ---------------- stage 3: back to sign-magnitude, select result
    // low 16 product bits come from a_frac*b_frac alone, so no carry in
    assign w_mulp   = {r_p_ii2, 16'b0} + r_mid2[47:0] + 48'(r_p_ff2[31:16]);
    assign w_addmag = r_sum2[47] ? 48'(-r_sum2) : r_sum2;

    always_comb begin
        n_sgn3  = 1'b0;
        n_int3  = '0;
        n_frac3 = '0;
        n_iout3 = '0;
        unique case (r_req2)
            smq32_alu_pkg::REQ_FROM_INT: begin
                n_sgn3 = r_sgn2;
                n_int3 = r_int2;
            end
            smq32_alu_pkg::REQ_FROM_FLOAT: begin
                n_sgn3 = r_sgn2;
                if (r_fsat2) begin
                    n_int3  = smq32_alu_pkg::INT_SAT;
                    n_frac3 = smq32_alu_pkg::FRAC_SAT;
                end else begin
                    n_int3  = r_fv2[47:16];
                    n_frac3 = r_fv2[15:0];
                end
            end
            smq32_alu_pkg::REQ_ADD: begin
                n_sgn3  = r_sum2[47];
                n_int3  = w_addmag[47:16];
                n_frac3 = w_addmag[15:0];
            end
            smq32_alu_pkg::REQ_MULT: begin
                n_sgn3  = r_sgn2;
                n_int3  = w_mulp[47:16];
                n_frac3 = w_mulp[15:0];
            end
            smq32_alu_pkg::REQ_TO_INT: begin
                n_iout3 = r_int2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_rdy3) begin
            r_req3  <= r_req2;
            r_sgn3  <= n_sgn3;
            r_int3  <= n_int3;
            r_frac3 <= n_frac3;
            r_iout3 <= n_iout3;
        end
    end

    assign o_res.valid   = r_v3;
    assign o_res.r_sign  = r_sgn3;
    assign o_res.r_int   = r_int3;
    assign o_res.r_frac  = r_frac3;
    assign o_res.int_out = r_iout3;

    // ---------------- checks
    `SMQ_ASSERT(a_full_when_blocked, i_clk, i_rst_n, !i_req.ready |-> (r_v1 && r_v2 && r_v3))
    `SMQ_ASSERT(a_accept_enters, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> r_v1)
    `SMQ_ASSERT(a_mid_holds, i_clk, i_rst_n, (r_v2 && !w_rdy3) |=> r_v2)
    `SMQ_ASSERT(a_int_out_only_to_int, i_clk, i_rst_n, (o_res.valid && o_res.int_out != '0) |-> (r_req3 == smq32_alu_pkg::REQ_TO_INT))
    `SMQ_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !r_v3)

endmodule
